// ----- hw/rtl/srrs_pkg.sv -----
package srrs_pkg;

    localparam int BLOCK_W = 4;
    localparam int KIND_W  = 2;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FETCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_GATE  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BLOCK_W-1:0] block;
        logic               op_done;
        logic               iface_busy;
        logic               gate_value;
    } srrs_req_t;

    typedef struct packed {
        logic               accepted;
        logic [KIND_W-1:0]  finished_kind;
        logic [BLOCK_W-1:0] finished_block;
        logic [KIND_W-1:0]  started_kind;
        logic [BLOCK_W-1:0] started_block;
        logic               busy_res;
        logic               queried_write_pending;
        logic               queried_fetch_pending;
    } srrs_res_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } srrs_ctrl_t;

endpackage

// ----- hw/rtl/srrs_req_if.sv -----
interface srrs_req_if;
    import srrs_pkg::*;

    logic      valid;
    logic      ready;
    srrs_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/srrs_res_if.sv -----
interface srrs_res_if;
    import srrs_pkg::*;

    logic      valid;
    logic      ready;
    srrs_res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/storage_request_round_robin_scheduler.sv -----
// flow: an accepted item is captured into the request register, then the state update and
// result register load follow in the execute state; a new item is taken only after that;
// the update waits while the previous result is still held in the output register
// reset: all pending flags clear, accept gate suspended, no operation running,
// scan pointer on the last block
module storage_request_round_robin_scheduler #(
    parameter int BLOCK_COUNT = 16
) (
    input logic       clk,
    input logic       rst_n,
    srrs_req_if.sink  request,
    srrs_res_if.source result
);
    import srrs_pkg::*;

    srrs_ctrl_t ctrl;

    srrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .ctrl      (ctrl)
    );

    srrs_dp #(
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .req   (request.payload),
        .res   (result.payload)
    );

endmodule

// ----- hw/rtl/srrs_ctrl.sv -----
module srrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output srrs_pkg::srrs_ctrl_t ctrl
);
    import srrs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        ctrl.capture   = 1'b0;
        ctrl.commit    = 1'b0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // result register must be free before the state is updated
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.commit    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/srrs_dp.sv -----
module srrs_dp #(
    parameter int BLOCK_COUNT = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  srrs_pkg::srrs_ctrl_t ctrl,
    input  srrs_pkg::srrs_req_t  req,
    output srrs_pkg::srrs_res_t  res
);
    import srrs_pkg::*;

    localparam int PW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int CW = (PW > BLOCK_W) ? PW : BLOCK_W;

    srrs_req_t req_reg;
    srrs_res_t res_reg;
    srrs_res_t res_next;

    logic [BLOCK_COUNT-1:0] wflag_reg;
    logic [BLOCK_COUNT-1:0] wflag_next;
    logic [BLOCK_COUNT-1:0] fflag_reg;
    logic [BLOCK_COUNT-1:0] fflag_next;
    logic                   gate_reg;
    logic                   gate_next;
    logic [KIND_W-1:0]      run_kind_reg;
    logic [KIND_W-1:0]      run_kind_next;
    logic [PW-1:0]          run_block_reg;
    logic [PW-1:0]          run_block_next;
    logic [PW-1:0]          ptr_reg;
    logic [PW-1:0]          ptr_next;

    logic [BLOCK_COUNT-1:0] pend;
    logic [BLOCK_COUNT-1:0] sel;
    logic [CW-1:0]          blk_ext;
    logic                   hit_hi;
    logic                   hit_any;
    logic [PW-1:0]          idx_hi;
    logic [PW-1:0]          idx_any;
    logic [PW-1:0]          pick;
    logic                   retire;
    logic                   in_range;

    // block decode and round-robin pick after the pointer
    always_comb
    begin
        blk_ext = CW'(req_reg.block);
        pend    = wflag_reg | fflag_reg;
        sel     = '0;
        hit_hi  = 1'b0;
        hit_any = 1'b0;
        idx_hi  = '0;
        idx_any = '0;
        for (int i = BLOCK_COUNT - 1; i >= 0; i--)
        begin
            sel[i] = (blk_ext == CW'(i));
            if (pend[i])
            begin
                hit_any = 1'b1;
                idx_any = PW'(i);
                if (PW'(i) > ptr_reg)
                begin
                    hit_hi = 1'b1;
                    idx_hi = PW'(i);
                end
            end
        end
        pick     = hit_hi ? idx_hi : idx_any;
        in_range = |sel;
    end

    always_comb
    begin
        wflag_next     = wflag_reg;
        fflag_next     = fflag_reg;
        gate_next      = gate_reg;
        run_kind_next  = run_kind_reg;
        run_block_next = run_block_reg;
        ptr_next       = ptr_reg;
        retire         = 1'b0;
        res_next       = '0;
        case (req_reg.cmd)
            CMD_TICK:
            begin
                retire = (run_kind_reg != KIND_NONE) && req_reg.op_done;
                if (retire)
                begin
                    res_next.finished_kind  = run_kind_reg;
                    res_next.finished_block = BLOCK_W'(CW'(run_block_reg));
                    run_kind_next           = KIND_NONE;
                end
                if ((run_kind_next == KIND_NONE) && !req_reg.iface_busy
                    && (hit_any || hit_hi))
                begin
                    ptr_next       = pick;
                    run_block_next = pick;
                    if (wflag_reg[pick])
                    begin
                        wflag_next[pick] = 1'b0;
                        run_kind_next    = KIND_WRITE;
                    end
                    else
                    begin
                        fflag_next[pick] = 1'b0;
                        run_kind_next    = KIND_FETCH;
                    end
                    res_next.started_kind  = run_kind_next;
                    res_next.started_block = BLOCK_W'(CW'(pick));
                end
            end
            CMD_WRITE, CMD_FETCH:
            begin
                if (in_range && gate_reg && !(|(pend & sel)))
                begin
                    if (req_reg.cmd == CMD_WRITE)
                    begin
                        wflag_next = wflag_reg | sel;
                    end
                    else
                    begin
                        fflag_next = fflag_reg | sel;
                    end
                    res_next.accepted = 1'b1;
                end
            end
            CMD_GATE:
            begin
                gate_next = req_reg.gate_value;
            end
            default:
            begin
                gate_next = gate_reg;
            end
        endcase
        res_next.busy_res = (run_kind_next != KIND_NONE) || (|(wflag_next | fflag_next));
        res_next.queried_write_pending = |(wflag_next & sel);
        res_next.queried_fetch_pending = |(fflag_next & sel);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            req_reg <= req;
        end
        if (ctrl.commit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wflag_reg     <= '0;
            fflag_reg     <= '0;
            gate_reg      <= 1'b0;
            run_kind_reg  <= KIND_NONE;
            run_block_reg <= '0;
            ptr_reg       <= PW'(BLOCK_COUNT - 1);
        end
        else if (ctrl.commit)
        begin
            wflag_reg     <= wflag_next;
            fflag_reg     <= fflag_next;
            gate_reg      <= gate_next;
            run_kind_reg  <= run_kind_next;
            run_block_reg <= run_block_next;
            ptr_reg       <= ptr_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- hw/rtl/srrs_checker.sv -----
module srrs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input srrs_pkg::srrs_res_t out_payload
);
    import srrs_pkg::*;

    // pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result dropped or changed while stalled");

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item still in work");

    a_accept_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.accepted |->
            out_payload.finished_kind == KIND_NONE && out_payload.started_kind == KIND_NONE)
        else $error("request accepted together with retire or start");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.started_kind != KIND_NONE |->
            out_payload.busy_res && out_payload.started_kind <= KIND_FETCH)
        else $error("started operation without busy");

    a_finish_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_payload.finished_kind <= KIND_FETCH)
        else $error("bad finished kind");

endmodule

bind storage_request_round_robin_scheduler srrs_checker u_srrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (request.valid),
    .in_ready    (request.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_payload (result.payload)
);

// ----- test/tb_storage_request_round_robin_scheduler.sv -----
`timescale 1ns / 1ps

module tb_storage_request_round_robin_scheduler;
    import srrs_pkg::*;

    localparam int NBLK        = 16;
    localparam int RAND_ITEMS  = 1350;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_PRINTS  = 40;
    localparam int DIR_ROWS    = 24;

    localparam srrs_res_t RES_NONE = '0;

    typedef struct {
        srrs_req_t req;
        bit        typed;
        srrs_res_t res;
    } stim_row_t;

    // req: {cmd, block, op_done, iface_busy, gate_value}
    // res: {accepted, fin kind, fin block, start kind, start block, busy, wr, fe}
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ {CMD_TICK,  4'd0,  1'b1, 1'b0, 1'b0}, 1'b1, RES_NONE },
        '{ {CMD_WRITE, 4'd0,  1'b0, 1'b0, 1'b0}, 1'b1, RES_NONE },
        '{ {CMD_FETCH, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b1, RES_NONE },
        '{ {CMD_GATE,  4'd15, 1'b0, 1'b0, 1'b1}, 1'b1, RES_NONE },
        '{ {CMD_WRITE, 4'd0,  1'b0, 1'b0, 1'b0}, 1'b1,
           {1'b1, KIND_NONE, 4'd0, KIND_NONE, 4'd0, 1'b1, 1'b1, 1'b0} },
        '{ {CMD_FETCH, 4'd0,  1'b0, 1'b0, 1'b0}, 1'b1,
           {1'b0, KIND_NONE, 4'd0, KIND_NONE, 4'd0, 1'b1, 1'b1, 1'b0} },
        '{ {CMD_FETCH, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b1,
           {1'b1, KIND_NONE, 4'd0, KIND_NONE, 4'd0, 1'b1, 1'b0, 1'b1} },
        '{ {CMD_WRITE, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b1,
           {1'b0, KIND_NONE, 4'd0, KIND_NONE, 4'd0, 1'b1, 1'b0, 1'b1} },
        '{ {CMD_TICK,  4'd0,  1'b1, 1'b1, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_TICK,  4'd0,  1'b0, 1'b0, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_TICK,  4'd0,  1'b0, 1'b0, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_WRITE, 4'd0,  1'b1, 1'b1, 1'b1}, 1'b0, RES_NONE },
        '{ {CMD_TICK,  4'd15, 1'b1, 1'b0, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_TICK,  4'd0,  1'b1, 1'b1, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_TICK,  4'd0,  1'b1, 1'b0, 1'b1}, 1'b0, RES_NONE },
        '{ {CMD_GATE,  4'd5,  1'b0, 1'b0, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_FETCH, 4'd5,  1'b0, 1'b0, 1'b1}, 1'b0, RES_NONE },
        '{ {CMD_GATE,  4'd5,  1'b1, 1'b1, 1'b1}, 1'b0, RES_NONE },
        '{ {CMD_FETCH, 4'd5,  1'b0, 1'b0, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_WRITE, 4'd10, 1'b0, 1'b0, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_TICK,  4'd10, 1'b1, 1'b0, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_TICK,  4'd10, 1'b1, 1'b0, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_TICK,  4'd10, 1'b1, 1'b0, 1'b0}, 1'b0, RES_NONE },
        '{ {CMD_TICK,  4'd3,  1'b0, 1'b0, 1'b0}, 1'b0, RES_NONE }
    };

    logic clk;
    logic rst_n;

    srrs_req_if request_ch ();
    srrs_res_if result_ch ();

    storage_request_round_robin_scheduler #(
        .BLOCK_COUNT(NBLK)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request_ch),
        .result (result_ch)
    );

    // scheduler state mirror
    logic [NBLK-1:0]    wr_pend;
    logic [NBLK-1:0]    fe_pend;
    logic               gate_open;
    logic [KIND_W-1:0]  run_kind;
    logic [BLOCK_W-1:0] run_blk;
    int                 scan_ptr;

    srrs_res_t expected_results [$];

    bit no_gaps;
    bit hold_off_req;
    int error_count   = 0;
    int idle_cycles   = 0;
    int checked_count = 0;
    int taken_count   = 0;
    int started_count = 0;
    int retired_count = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic srrs_res_t schedule_step(input srrs_req_t r);
        srrs_res_t o;
        bit        found;
        int        n;
        o = '0;
        found = 1'b0;
        case (r.cmd)
            CMD_TICK:
            begin
                if (run_kind != KIND_NONE && r.op_done)
                begin
                    o.finished_kind  = run_kind;
                    o.finished_block = run_blk;
                    run_kind = KIND_NONE;
                end
                if (run_kind == KIND_NONE && !r.iface_busy)
                begin
                    for (n = 0; n < NBLK; n++)
                    begin
                        if (!found)
                        begin
                            scan_ptr = (scan_ptr + 1 >= NBLK) ? 0 : scan_ptr + 1;
                            if (wr_pend[scan_ptr])
                            begin
                                wr_pend[scan_ptr] = 1'b0;
                                run_kind = KIND_WRITE;
                                run_blk  = scan_ptr[BLOCK_W-1:0];
                                found    = 1'b1;
                            end
                            else if (fe_pend[scan_ptr])
                            begin
                                fe_pend[scan_ptr] = 1'b0;
                                run_kind = KIND_FETCH;
                                run_blk  = scan_ptr[BLOCK_W-1:0];
                                found    = 1'b1;
                            end
                        end
                    end
                    if (run_kind != KIND_NONE)
                    begin
                        o.started_kind  = run_kind;
                        o.started_block = run_blk;
                    end
                end
            end
            CMD_WRITE, CMD_FETCH:
            begin
                if (gate_open && !wr_pend[r.block] && !fe_pend[r.block])
                begin
                    if (r.cmd == CMD_WRITE)
                        wr_pend[r.block] = 1'b1;
                    else
                        fe_pend[r.block] = 1'b1;
                    o.accepted = 1'b1;
                end
            end
            default:
            begin
                gate_open = r.gate_value;
            end
        endcase
        o.queried_write_pending = wr_pend[r.block];
        o.queried_fetch_pending = fe_pend[r.block];
        o.busy_res = (run_kind != KIND_NONE) || (|wr_pend) || (|fe_pend);
        return o;
    endfunction

    function automatic srrs_req_t rand_request();
        srrs_req_t r;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.cmd = CMD_TICK;
        else if (pick < 65)
            r.cmd = CMD_WRITE;
        else if (pick < 90)
            r.cmd = CMD_FETCH;
        else
            r.cmd = CMD_GATE;
        r.block      = BLOCK_W'($urandom_range(0, NBLK - 1));
        r.op_done    = 1'($urandom_range(0, 1));
        r.iface_busy = ($urandom_range(0, 99) < 25);
        // keep the gate mostly open so requests get through
        r.gate_value = ($urandom_range(0, 99) < 75);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input srrs_req_t r, input bit typed, input srrs_res_t want);
        srrs_res_t predicted;
        while (!no_gaps && $urandom_range(0, 99) < 14)
        begin
            request_ch.valid <= 1'b0;
            @(negedge clk);
        end
        request_ch.valid   <= 1'b1;
        request_ch.payload <= r;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        predicted = schedule_step(r);
        expected_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    initial
    begin
        int k;
        wr_pend      = '0;
        fe_pend      = '0;
        gate_open    = 1'b0;
        run_kind     = KIND_NONE;
        run_blk      = '0;
        scan_ptr     = NBLK - 1;
        no_gaps      = 1'b0;
        hold_off_req = 1'b0;
        rst_n              = 1'b0;
        request_ch.valid   = 1'b0;
        request_ch.payload = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
            send_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);

        for (k = 0; k < RAND_ITEMS; k++)
        begin
            no_gaps = (k >= 300 && k < 500);
            if (k == 800)
                hold_off_req = 1'b1;
            send_item(rand_request(), 1'b0, RES_NONE);
        end
        request_ch.valid <= 1'b0;
        no_gaps = 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d results: %0d requests taken, %0d operations started, %0d retired",
                 checked_count, taken_count, started_count, retired_count);
        $display("directed rows, %0d random items, one long output stall", RAND_ITEMS);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        bit held;
        held = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !held)
            begin
                result_ch.ready <= 1'b0;
                held = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        srrs_res_t got;
        srrs_res_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.payload;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected item", 1, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                checked_count++;
                if (got.accepted)
                    taken_count++;
                if (got.started_kind != KIND_NONE)
                    started_count++;
                if (got.finished_kind != KIND_NONE)
                    retired_count++;
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", got.accepted, want.accepted);
                if (got.finished_kind !== want.finished_kind)
                    report_mismatch("finished_kind", got.finished_kind, want.finished_kind);
                if (got.finished_block !== want.finished_block)
                    report_mismatch("finished_block", got.finished_block, want.finished_block);
                if (got.started_kind !== want.started_kind)
                    report_mismatch("started_kind", got.started_kind, want.started_kind);
                if (got.started_block !== want.started_block)
                    report_mismatch("started_block", got.started_block, want.started_block);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.queried_write_pending !== want.queried_write_pending)
                    report_mismatch("queried_write_pending", got.queried_write_pending,
                                    want.queried_write_pending);
                if (got.queried_fetch_pending !== want.queried_fetch_pending)
                    report_mismatch("queried_fetch_pending", got.queried_fetch_pending,
                                    want.queried_fetch_pending);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
